@@ design/pimr_pkg.sv @@
// Package for the point-in-mesh ray test: states, register indexes and constants.
`default_nettype none
package pimr_pkg;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_SAT   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_POINT_X     = 2'd0,
    REG_POINT_Y     = 2'd1,
    REG_POINT_Z     = 2'd2,
    REG_DET_EPSILON = 2'd3
  } reg_idx_e;

  // Product pairs issued to the shared multiplier, two products each
  typedef enum logic [2:0] {
    PAIR_DET = 3'd0,
    PAIR_NU  = 3'd1,
    PAIR_QX  = 3'd2,
    PAIR_QY  = 3'd3,
    PAIR_QZ  = 3'd4,
    PAIR_NTX = 3'd5,
    PAIR_NTY = 3'd6,
    PAIR_NTZ = 3'd7
  } pair_e;

  localparam int unsigned DIST_W = 63;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam int unsigned QUOT_STEPS = 63;
  localparam logic [31:0] EPS_RESET = 32'd1;

endpackage
`default_nettype wire

@@ design/pimr_if.sv @@
// Stream interfaces for triangle beats in and result beats out.
`default_nettype none
interface pimr_tri_if;
  logic        valid;
  logic        ready;
  logic [31:0] vert_a_x;
  logic [31:0] vert_a_y;
  logic [31:0] vert_a_z;
  logic [31:0] vert_b_x;
  logic [31:0] vert_b_y;
  logic [31:0] vert_b_z;
  logic [31:0] vert_c_x;
  logic [31:0] vert_c_y;
  logic [31:0] vert_c_z;
  logic        last_triangle;
  modport source (output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
                  vert_c_x, vert_c_y, vert_c_z, last_triangle, input ready);
  modport sink (input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
                vert_c_x, vert_c_y, vert_c_z, last_triangle, output ready);
endinterface

interface pimr_res_if;
  logic        valid;
  logic        ready;
  logic        point_inside;
  logic        any_hit;
  logic [62:0] nearest_distance;
  modport source (output valid, point_inside, any_hit, nearest_distance, input ready);
  modport sink (input valid, point_inside, any_hit, nearest_distance, output ready);
endinterface
`default_nettype wire

@@ design/point_in_mesh_ray_test.sv @@
// Top level: ray-cast point-in-mesh test with one shared multiplier and a serial divider.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------
//  in_i     | in  | valid/ready      | triangle vertices a,b,c and last_triangle
//  out_o    | out | valid/ready      | point_inside, any_hit, nearest_distance
//  apb      | in  | psel/penable     | point_x/y/z, det_epsilon at 0x0..0xC
//
// A triangle passes through the multiplier steps, a check step, a saturation step,
// the divider steps (one quotient bit each) and a merge step. The bit-serial
// divider dominates on hitting triangles; skipped and saturated ones bypass it.
// in_i.ready is high only while idle. After the last triangle the result beat holds
// until taken. rst_ni clears the kept hit and the registers at once; no clearing pass.
`default_nettype none
module point_in_mesh_ray_test #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  pimr_tri_if.sink          in_i,
  pimr_res_if.source        out_o,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [3:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned DW  = COORD_WIDTH + 1;   // coordinate difference
  localparam int unsigned PW  = 2 * DW;            // product of two differences
  localparam int unsigned QW  = PW + 1;            // cross product term
  localparam int unsigned SPL = DW + 1;            // low split of a cross term
  localparam int unsigned MA  = DW + 2;            // multiplier operand a
  localparam int unsigned MPW = MA + DW;           // multiplier product
  localparam int unsigned NTW = QW + DW + 2;       // t numerator
  localparam int unsigned NW  = NTW + 16;          // scaled t numerator
  localparam int unsigned QS  = pimr_pkg::QUOT_STEPS;
  localparam int unsigned CW  = QW + QS;           // saturation compare width
  localparam int unsigned DWI = pimr_pkg::DIST_W;

  // Configuration registers
  logic [31:0] point_x_q, point_y_q, point_z_q, det_eps_q;
  logic        cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q <= '0;
      point_y_q <= '0;
      point_z_q <= '0;
      det_eps_q <= pimr_pkg::EPS_RESET;
    end else if (cfg_wr) begin
      unique case (pimr_pkg::reg_idx_e'(paddr[3:2]))
        pimr_pkg::REG_POINT_X:     point_x_q <= pwdata;
        pimr_pkg::REG_POINT_Y:     point_y_q <= pwdata;
        pimr_pkg::REG_POINT_Z:     point_z_q <= pwdata;
        pimr_pkg::REG_DET_EPSILON: det_eps_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pimr_pkg::reg_idx_e'(paddr[3:2]))
      pimr_pkg::REG_POINT_X:     prdata = point_x_q;
      pimr_pkg::REG_POINT_Y:     prdata = point_y_q;
      pimr_pkg::REG_POINT_Z:     prdata = point_z_q;
      pimr_pkg::REG_DET_EPSILON: prdata = det_eps_q;
      default:                   prdata = '0;
    endcase
  end

  function automatic logic signed [DW-1:0] sx(input logic [31:0] v);
    sx = $signed({v[COORD_WIDTH-1], v[COORD_WIDTH-1:0]});
  endfunction

  pimr_pkg::state_e state_q, state_d;
  logic [4:0]  step_q;
  logic [5:0]  cnt_q;

  logic signed [DW-1:0] abx_q, aby_q, abz_q, acx_q, acy_q, acz_q, tvx_q, tvy_q, tvz_q;
  logic                 last_q;
  logic signed [MPW-1:0] p_q;
  logic signed [QW-1:0]  acc_q, det_q, nu_q, qx_q, qy_q, qz_q;
  logic signed [NTW-1:0] nt_q;
  logic [QW-1:0]  d_q, r_q;
  logic [CW-1:0]  nx_q;
  logic [DWI-1:0] t_q;
  logic           negdet_q, hit_q;

  logic [DWI-1:0] nearest_q;
  logic           inside_q, seen_q;
  logic           out_valid_q, out_inside_q, out_hit_q;
  logic [DWI-1:0] out_dist_q;

  assign in_i.ready             = (state_q == pimr_pkg::ST_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.point_inside     = out_inside_q;
  assign out_o.any_hit          = out_hit_q;
  assign out_o.nearest_distance = out_dist_q;

  // Select multiplier operands for the current beat
  logic [2:0]            pair;
  logic                  half;
  logic signed [QW-1:0]  qsel;
  logic signed [MA-1:0]  ma;
  logic signed [DW-1:0]  mb;
  logic signed [MA-1:0]  qlo, qhi;
  assign pair = step_q[3:1];
  assign half = step_q[0];

  always_comb begin
    ma   = '0;
    mb   = '0;
    qsel = qx_q;
    unique case (pimr_pkg::pair_e'(pair))
      pimr_pkg::PAIR_DET: begin
        ma = MA'(half ? abx_q : aby_q);
        mb = half ? acy_q : acx_q;
      end
      pimr_pkg::PAIR_NU: begin
        ma = MA'(half ? tvx_q : tvy_q);
        mb = half ? acy_q : acx_q;
      end
      pimr_pkg::PAIR_QX: begin
        ma = MA'(half ? tvz_q : tvy_q);
        mb = half ? aby_q : abz_q;
      end
      pimr_pkg::PAIR_QY: begin
        ma = MA'(half ? tvx_q : tvz_q);
        mb = half ? abz_q : abx_q;
      end
      pimr_pkg::PAIR_QZ: begin
        ma = MA'(half ? tvy_q : tvx_q);
        mb = half ? abx_q : aby_q;
      end
      pimr_pkg::PAIR_NTX: begin
        qsel = qx_q;
        mb   = acx_q;
      end
      pimr_pkg::PAIR_NTY: begin
        qsel = qy_q;
        mb   = acy_q;
      end
      pimr_pkg::PAIR_NTZ: begin
        qsel = qz_q;
        mb   = acz_q;
      end
      default: ;
    endcase
    qlo = $signed({1'b0, qsel[SPL-1:0]});
    qhi = MA'($signed(qsel[QW-1:SPL]));
    if (pair >= pimr_pkg::PAIR_NTX) ma = half ? qhi : qlo;
  end

  // Accumulate the product of the previous beat
  logic [4:0]           jstep;
  logic [2:0]           jpair;
  logic                 jhalf;
  logic signed [QW-1:0] pc, diff;
  logic signed [NTW-1:0] pn;
  assign jstep = step_q - 5'd1;
  assign jpair = jstep[3:1];
  assign jhalf = jstep[0];
  assign pc    = p_q[QW-1:0];
  assign diff  = acc_q - pc;
  assign pn    = NTW'(p_q);

  // Hit tests on the finished numerators
  logic                 neg;
  logic signed [QW-1:0] d_c, nu_n, nv_n;
  logic signed [NTW-1:0] nt_n;
  logic signed [QW:0]   uv_sum;
  logic                 skip;
  assign neg    = det_q[QW-1];
  assign d_c    = neg ? -det_q : det_q;
  assign nu_n   = neg ? -nu_q : nu_q;
  assign nv_n   = neg ? -qz_q : qz_q;
  assign nt_n   = neg ? -nt_q : nt_q;
  assign uv_sum = (QW+1)'(nu_n) + (QW+1)'(nv_n);
  assign skip   = (d_c == '0) || (d_c < $signed({{(QW-32){1'b0}}, det_eps_q}))
               || nu_n[QW-1] || (d_c < nu_n) || nv_n[QW-1]
               || ($signed({1'b0, d_c}) < uv_sum) || nt_n[NTW-1];

  // Divider step
  logic [QW:0] rs;
  logic        ge;
  logic [QW:0] rsub;
  assign rs   = {r_q, nx_q[QS-1]};
  assign ge   = rs >= {1'b0, d_q};
  assign rsub = rs - {1'b0, d_q};

  // Merge into the kept hit
  logic upd;
  logic [DWI-1:0] near_n;
  logic inside_n, seen_n;
  assign upd      = hit_q && (!seen_q || (t_q < nearest_q));
  assign near_n   = upd ? t_q : nearest_q;
  assign inside_n = upd ? negdet_q : inside_q;
  assign seen_n   = seen_q || hit_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pimr_pkg::ST_IDLE:  if (in_i.valid) state_d = pimr_pkg::ST_MUL;
      pimr_pkg::ST_MUL:   if (step_q[4]) state_d = pimr_pkg::ST_CHECK;
      pimr_pkg::ST_CHECK: state_d = pimr_pkg::ST_SAT;
      pimr_pkg::ST_SAT: begin
        if (!hit_q || (nx_q >= {d_q, {QS{1'b0}}})) state_d = pimr_pkg::ST_FIN;
        else state_d = pimr_pkg::ST_DIV;
      end
      pimr_pkg::ST_DIV:   if (cnt_q == 6'(QS-1)) state_d = pimr_pkg::ST_FIN;
      pimr_pkg::ST_FIN:   state_d = last_q ? pimr_pkg::ST_OUT : pimr_pkg::ST_IDLE;
      pimr_pkg::ST_OUT:   if (out_o.ready) state_d = pimr_pkg::ST_IDLE;
      default:            state_d = pimr_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pimr_pkg::ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      nearest_q   <= pimr_pkg::DIST_MAX;
      inside_q    <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == pimr_pkg::ST_IDLE) step_q <= '0;
      else if (state_q == pimr_pkg::ST_MUL) step_q <= step_q + 5'd1;
      if (state_q == pimr_pkg::ST_SAT) cnt_q <= '0;
      else if (state_q == pimr_pkg::ST_DIV) cnt_q <= cnt_q + 6'd1;
      if (state_q == pimr_pkg::ST_FIN) begin
        if (last_q) begin
          nearest_q   <= pimr_pkg::DIST_MAX;
          inside_q    <= 1'b0;
          seen_q      <= 1'b0;
          out_valid_q <= 1'b1;
        end else begin
          nearest_q <= near_n;
          inside_q  <= inside_n;
          seen_q    <= seen_n;
        end
      end
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pimr_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          abx_q  <= sx(in_i.vert_b_x) - sx(in_i.vert_a_x);
          aby_q  <= sx(in_i.vert_b_y) - sx(in_i.vert_a_y);
          abz_q  <= sx(in_i.vert_b_z) - sx(in_i.vert_a_z);
          acx_q  <= sx(in_i.vert_c_x) - sx(in_i.vert_a_x);
          acy_q  <= sx(in_i.vert_c_y) - sx(in_i.vert_a_y);
          acz_q  <= sx(in_i.vert_c_z) - sx(in_i.vert_a_z);
          tvx_q  <= sx(point_x_q) - sx(in_i.vert_a_x);
          tvy_q  <= sx(point_y_q) - sx(in_i.vert_a_y);
          tvz_q  <= sx(point_z_q) - sx(in_i.vert_a_z);
          last_q <= in_i.last_triangle;
        end
      end
      pimr_pkg::ST_MUL: begin
        if (!step_q[4]) p_q <= ma * MA'(mb);
        if (step_q != '0) begin
          if (jpair < pimr_pkg::PAIR_NTX) begin
            if (!jhalf) acc_q <= pc;
            else begin
              unique case (pimr_pkg::pair_e'(jpair))
                pimr_pkg::PAIR_DET: det_q <= diff;
                pimr_pkg::PAIR_NU:  nu_q  <= diff;
                pimr_pkg::PAIR_QX:  qx_q  <= diff;
                pimr_pkg::PAIR_QY:  qy_q  <= diff;
                default:            qz_q  <= diff;
              endcase
            end
          end else begin
            if (jhalf) nt_q <= nt_q + (pn <<< SPL);
            else if (jpair == pimr_pkg::PAIR_NTX) nt_q <= pn;
            else nt_q <= nt_q + pn;
          end
        end
      end
      pimr_pkg::ST_CHECK: begin
        d_q      <= d_c;
        negdet_q <= neg;
        hit_q    <= !skip;
        nx_q     <= {{(CW-NW){1'b0}}, nt_n, 16'b0};
      end
      pimr_pkg::ST_SAT: begin
        t_q <= pimr_pkg::DIST_MAX;
        r_q <= nx_q[CW-1:QS];
      end
      pimr_pkg::ST_DIV: begin
        r_q  <= ge ? rsub[QW-1:0] : rs[QW-1:0];
        nx_q <= nx_q << 1;
        t_q  <= {t_q[DWI-2:0], ge};
      end
      pimr_pkg::ST_FIN: begin
        if (last_q) begin
          out_inside_q <= inside_n;
          out_hit_q    <= seen_n;
          out_dist_q   <= near_n;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ design/pimr_checker.sv @@
// Port-level checker for the point-in-mesh ray test, bound to the top level.
`default_nettype none
module pimr_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire        point_inside_i,
  input wire        any_hit_i,
  input wire [62:0] nearest_distance_i,
  input wire        pready_i
);

  // Hold a stalled result beat
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // No result right after a triangle beat is taken
  ap_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i)
    else $error("result appeared one cycle after a triangle");

  // Take no triangle while a result waits
  ap_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("triangle taken while a result waits");

  // No hit means outside and maximum distance
  ap_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !any_hit_i |-> !point_inside_i && (nearest_distance_i == {63{1'b1}}))
    else $error("miss result carries hit data");

  ap_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready low");

endmodule

bind point_in_mesh_ray_test pimr_checker u_pimr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .point_inside_i     (out_o.point_inside),
  .any_hit_i          (out_o.any_hit),
  .nearest_distance_i (out_o.nearest_distance),
  .pready_i           (pready)
);
`default_nettype wire

@@ tb/sv/point_in_mesh_ray_test_tb.sv @@
// Testbench for the point-in-mesh ray test: random meshes checked against a local predictor.
`timescale 1ns / 100ps
`default_nettype none
module point_in_mesh_ray_test_tb;

  typedef struct packed {
    logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic        last;
  } tri_t;

  typedef struct packed {
    logic        is_in;
    logic        hit;
    logic [62:0] distance;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pimr_tri_if tri_bus ();
  pimr_res_if res_bus ();

  point_in_mesh_ray_test u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(tri_bus.sink), .out_o(res_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: configuration and kept hit
  logic signed [31:0] pt_x, pt_y, pt_z;
  logic [31:0]        eps;
  logic [62:0]        kept_dist;
  logic               kept_inside, kept_hit;

  tri_t     pending_tris[$];
  verdict_t expected_verdicts[$];
  int       send_idle_pct = 0, recv_idle_pct = 0;
  bit       recv_hold = 1'b0;
  int       n_errors = 0;
  bit       feeding = 1'b0;
  bit       beat_taken = 1'b0;

  // Ray along +z, exact Moller-Trumbore numerators; fold one triangle into the kept hit
  function automatic void fold_triangle(input tri_t tr);
    logic signed [127:0] ax, ay, az, abx, aby, abz, acx, acy, acz, tvx, tvy, tvz;
    logic signed [127:0] det, nu, nv, nt, qx, qy;
    logic [127:0] num, quo;
    logic [62:0] t;
    bit neg;
    ax = $signed(tr.ax); ay = $signed(tr.ay); az = $signed(tr.az);
    abx = $signed(tr.bx) - ax; aby = $signed(tr.by) - ay; abz = $signed(tr.bz) - az;
    acx = $signed(tr.cx) - ax; acy = $signed(tr.cy) - ay; acz = $signed(tr.cz) - az;
    tvx = pt_x - ax; tvy = pt_y - ay; tvz = pt_z - az;
    det = aby * acx - abx * acy;
    nu  = tvy * acx - tvx * acy;
    qx  = tvy * abz - tvz * aby;
    qy  = tvz * abx - tvx * abz;
    nv  = tvx * aby - tvy * abx;
    nt  = qx * acx + qy * acy + nv * acz;
    neg = det < 0;
    if (neg) begin
      det = -det; nu = -nu; nv = -nv; nt = -nt;
    end
    if (det == 0 || det < $signed({96'd0, eps})) return;
    if (nu < 0 || nu > det || nv < 0 || nu + nv > det || nt < 0) return;
    num = nt <<< 16;
    quo = num / det;
    t = (quo > {65'd0, pimr_pkg::DIST_MAX}) ? pimr_pkg::DIST_MAX : quo[62:0];
    if (!kept_hit || t < kept_dist) begin
      kept_dist = t; kept_inside = neg; kept_hit = 1'b1;
    end
  endfunction

  function automatic void predict(input tri_t tr);
    fold_triangle(tr);
    if (tr.last) begin
      expected_verdicts.push_back('{kept_inside, kept_hit, kept_dist});
      kept_dist = pimr_pkg::DIST_MAX; kept_inside = 1'b0; kept_hit = 1'b0;
    end
  endfunction

  // Predict and drop the head of the queue on each accepted beat
  always @(posedge clk_i) begin
    beat_taken = rst_ni && tri_bus.valid && tri_bus.ready;
    if (beat_taken) begin
      predict(pending_tris[0]);
      void'(pending_tris.pop_front());
    end
  end

  // Driver: hold a waiting beat, else idle at random or offer the head of the queue
  always @(negedge clk_i) begin
    tri_t nx;
    if (!rst_ni || pending_tris.size() == 0 || !feeding) begin
      tri_bus.valid <= 1'b0;
    end else if (tri_bus.valid && !beat_taken) begin
      tri_bus.valid <= 1'b1;
    end else begin
      nx = pending_tris[0];
      if ($urandom_range(99) < send_idle_pct) begin
        tri_bus.valid <= 1'b0;
      end else begin
        tri_bus.valid <= 1'b1;
        {tri_bus.vert_a_x, tri_bus.vert_a_y, tri_bus.vert_a_z, tri_bus.vert_b_x,
         tri_bus.vert_b_y, tri_bus.vert_b_z, tri_bus.vert_c_x, tri_bus.vert_c_y,
         tri_bus.vert_c_z, tri_bus.last_triangle} <= nx;
      end
    end
  end

  // Receiver readiness
  always @(negedge clk_i) begin
    res_bus.ready <= rst_ni && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_verdicts.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat inside=%b hit=%b dist=%h",
                                     res_bus.point_inside, res_bus.any_hit,
                                     res_bus.nearest_distance);
      end else begin
        want = expected_verdicts.pop_front();
        if (res_bus.point_inside !== want.is_in || res_bus.any_hit !== want.hit ||
            res_bus.nearest_distance !== want.distance) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp inside=%b hit=%b dist=%h, got inside=%b hit=%b dist=%h",
                     want.is_in, want.hit, want.distance, res_bus.point_inside,
                     res_bus.any_hit, res_bus.nearest_distance);
        end
      end
    end
  end

  task automatic write_reg(input pimr_pkg::reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      pimr_pkg::REG_POINT_X:     pt_x = val;
      pimr_pkg::REG_POINT_Y:     pt_y = val;
      pimr_pkg::REG_POINT_Z:     pt_z = val;
      pimr_pkg::REG_DET_EPSILON: eps = val;
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_point(input logic [31:0] x, y, z, e);
    write_reg(pimr_pkg::REG_POINT_X, x);
    write_reg(pimr_pkg::REG_POINT_Y, y);
    write_reg(pimr_pkg::REG_POINT_Z, z);
    write_reg(pimr_pkg::REG_DET_EPSILON, e);
  endtask

  // Drain queued triangles and results, then let the bench idle
  task automatic drain();
    feeding = 1'b1;
    wait (pending_tris.size() == 0 && !tri_bus.valid);
    wait (expected_verdicts.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord(input int scale);
    case (scale)
      0: return $urandom();
      1: return $signed($urandom_range(0, 20)) - 10 <<< 16;
      default: return $signed($urandom_range(0, 2000)) - 1000 <<< 10;
    endcase
  endfunction

  // Triangle around the point so the ray likely crosses it
  function automatic tri_t near_tri(input bit last);
    tri_t tr;
    int s;
    s = $urandom_range(2);
    tr.ax = pt_x + rnd_coord(s); tr.ay = pt_y + rnd_coord(s); tr.az = pt_z + rnd_coord(s);
    tr.bx = pt_x + rnd_coord(s); tr.by = pt_y + rnd_coord(s); tr.bz = pt_z + rnd_coord(s);
    tr.cx = pt_x + rnd_coord(s); tr.cy = pt_y + rnd_coord(s); tr.cz = pt_z + rnd_coord(s);
    if ($urandom_range(9) == 0) tr.cy = tr.ay;
    tr.last = last;
    return tr;
  endfunction

  task automatic add_mesh(input int n);
    for (int i = 0; i < n; i++) pending_tris.push_back(near_tri(i == n - 1));
  endtask

  initial begin
    tri_t tr;
    tri_bus.valid = 1'b0; tri_bus.last_triangle = 1'b0;
    {tri_bus.vert_a_x, tri_bus.vert_a_y, tri_bus.vert_a_z, tri_bus.vert_b_x,
     tri_bus.vert_b_y, tri_bus.vert_b_z, tri_bus.vert_c_x, tri_bus.vert_c_y,
     tri_bus.vert_c_z} = '0;
    res_bus.ready = 1'b0;
    pt_x = 0; pt_y = 0; pt_z = 0; eps = pimr_pkg::EPS_RESET;
    kept_dist = pimr_pkg::DIST_MAX; kept_inside = 1'b0; kept_hit = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: unit triangle above origin, both windings, edges, degenerate, extremes
    tr = '{32'h0, 32'h0, 32'h10000, 32'h10000, 32'h0, 32'h10000,
           32'h0, 32'h10000, 32'h10000, 1'b1};
    pending_tris.push_back(tr);
    tr = '{32'h0, 32'h0, 32'h20000, 32'h0, 32'h10000, 32'h20000,
           32'h10000, 32'h0, 32'h20000, 1'b1};
    pending_tris.push_back(tr);
    tr.az = 32'hFFFF0000; tr.bz = 32'hFFFF0000; tr.cz = 32'hFFFF0000;
    pending_tris.push_back(tr);
    tr = '{32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h5, 32'h20000, 32'h0, 32'h9, 1'b1};
    pending_tris.push_back(tr);
    tr = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
           32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1};
    pending_tris.push_back(tr);
    tr = '{32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1, 32'h7FFFFFFF,
           32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0};
    pending_tris.push_back(tr);
    tr = '{32'hFFFFFFFF, 32'h0, 32'h1, 32'h1, 32'hFFFFFFFF, 32'h1,
           32'h1, 32'h1, 32'h1, 1'b1};
    pending_tris.push_back(tr);
    for (int i = 0; i < 8; i++) pending_tris.push_back(near_tri(i[0]));
    drain();

    // Random phases over several settings, idle mix per phase
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_point(32'h0, 32'h0, 32'h0, 32'h0);
        1: set_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        2: set_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h1);
        default: set_point($urandom(), $urandom(), $urandom(), $urandom_range(0, 1000));
      endcase
      send_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 64 : 0;
      recv_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 23 : 0;
      for (int m = 0; m < 65; m++) begin
        if ($urandom_range(7) == 0) begin
          tr = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom(), 1'b1};
          pending_tris.push_back(tr);
        end else add_mesh($urandom_range(1, 8));
      end
      if (ph == 4) fork
        begin
          recv_hold = 1'b1;
          repeat (3000) @(posedge clk_i);
          recv_hold = 1'b0;
        end
      join_none
      drain();
    end

    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
